### rtl/core/mexp_pkg.sv
// ---------------------------------------------------------------------------
// mexp_pkg
// Shared constants and types for the modular exponentiation block.
// ---------------------------------------------------------------------------
`default_nettype none

package mexp_pkg;

	localparam int OPERAND_BITS_DEF = 31;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RED,
		ST_SQR,
		ST_MUL,
		ST_FIN
	} ctrl_state_t;

	// status of the shared modular multiplier
	typedef struct packed {
		logic run;
		logic done;
	} mm_stat_t;

endpackage

`default_nettype wire

### rtl/core/mexp_modmul.sv
// ---------------------------------------------------------------------------
// mexp_modmul
// Bit-serial modular multiplier: r = a * b mod m, one bit of b per cycle,
// most significant bit first, by double-and-add with reduction.
// ---------------------------------------------------------------------------
`default_nettype none

module mexp_modmul #(
	parameter int OPERAND_BITS = mexp_pkg::OPERAND_BITS_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    go,
	input  wire logic [OPERAND_BITS-1:0] a,
	input  wire logic [OPERAND_BITS-1:0] b,
	input  wire logic [OPERAND_BITS-1:0] modulus,
	output mexp_pkg::mm_stat_t           stat,
	output logic      [OPERAND_BITS-1:0] r
);

	localparam int CW = $clog2(OPERAND_BITS);

	logic                    run_q;
	logic                    done_q;
	logic [CW-1:0]           cnt_q;
	logic [OPERAND_BITS-1:0] a_q;
	logic [OPERAND_BITS-1:0] b_q;
	logic [OPERAND_BITS-1:0] r_q;
	logic [OPERAND_BITS:0]   dbl;
	logic [OPERAND_BITS:0]   dbl_red;
	logic [OPERAND_BITS:0]   sum;
	logic [OPERAND_BITS:0]   sum_red;
	logic [OPERAND_BITS:0]   m_ext;

	assign m_ext = {1'b0, modulus};

	// double, reduce, then add a when the current bit of b is set, reduce
	always_comb begin
		dbl     = {r_q, 1'b0};
		dbl_red = (dbl >= m_ext) ? dbl - m_ext : dbl;
		sum     = dbl_red + (b_q[OPERAND_BITS-1] ? {1'b0, a_q} : '0);
		sum_red = (sum >= m_ext) ? sum - m_ext : sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= CW'(OPERAND_BITS - 1);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			a_q <= a;
			b_q <= b;
			r_q <= '0;
		end else if (run_q) begin
			b_q <= {b_q[OPERAND_BITS-2:0], 1'b0};
			r_q <= sum_red[OPERAND_BITS-1:0];
		end
	end

	assign stat.run  = run_q;
	assign stat.done = done_q;
	assign r         = r_q;

endmodule

`default_nettype wire

### rtl/core/mexp_ctrl.sv
// ---------------------------------------------------------------------------
// mexp_ctrl
// Sequencer for left-to-right square-and-multiply: reduces the base, then
// walks the exponent from its top bit, issuing squares and multiplies.
// ---------------------------------------------------------------------------
`default_nettype none

module mexp_ctrl #(
	parameter int OPERAND_BITS = mexp_pkg::OPERAND_BITS_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	input  wire logic [OPERAND_BITS-1:0] base,
	input  wire logic [OPERAND_BITS-1:0] exponent,
	input  wire logic [OPERAND_BITS-1:0] modulus,
	input  mexp_pkg::mm_stat_t           mm_stat,
	input  wire logic [OPERAND_BITS-1:0] mm_r,
	output logic                         mm_go,
	output logic      [OPERAND_BITS-1:0] mm_a,
	output logic      [OPERAND_BITS-1:0] mm_b,
	output logic                         busy,
	output logic                         done,
	output logic      [OPERAND_BITS-1:0] power_result
);

	localparam int CW = $clog2(OPERAND_BITS);

	mexp_pkg::ctrl_state_t   state_q;
	mexp_pkg::ctrl_state_t   state_d;
	logic [OPERAND_BITS-1:0] exp_q;
	logic [CW-1:0]           bit_q;
	logic [OPERAND_BITS-1:0] bred_q;
	logic [OPERAND_BITS-1:0] z_q;
	logic [OPERAND_BITS-1:0] one_mod;
	logic                    last_bit;
	logic                    mm_done;

	assign one_mod  = {{(OPERAND_BITS-1){1'b0}}, (modulus != OPERAND_BITS'(1))};
	assign last_bit = (bit_q == '0);
	assign mm_done  = mm_stat.done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mexp_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		mm_go   = 1'b0;
		mm_a    = mm_r;
		mm_b    = mm_r;
		unique case (state_q)
			mexp_pkg::ST_IDLE: begin
				if (start) begin
					if (modulus == '0) begin
						state_d = mexp_pkg::ST_FIN;
					end else begin
						// base mod m = (1 mod m) * base mod m
						mm_go   = 1'b1;
						mm_a    = one_mod;
						mm_b    = base;
						state_d = mexp_pkg::ST_RED;
					end
				end
			end
			mexp_pkg::ST_RED: begin
				if (mm_done) begin
					mm_go   = 1'b1;
					mm_a    = one_mod;
					mm_b    = one_mod;
					state_d = mexp_pkg::ST_SQR;
				end
			end
			mexp_pkg::ST_SQR: begin
				if (mm_done) begin
					if (exp_q[OPERAND_BITS-1]) begin
						mm_go   = 1'b1;
						mm_b    = bred_q;
						state_d = mexp_pkg::ST_MUL;
					end else if (last_bit) begin
						state_d = mexp_pkg::ST_FIN;
					end else begin
						mm_go = 1'b1;
					end
				end
			end
			mexp_pkg::ST_MUL: begin
				if (mm_done) begin
					if (last_bit) begin
						state_d = mexp_pkg::ST_FIN;
					end else begin
						mm_go   = 1'b1;
						state_d = mexp_pkg::ST_SQR;
					end
				end
			end
			mexp_pkg::ST_FIN: begin
				state_d = mexp_pkg::ST_IDLE;
			end
			default: begin
				state_d = mexp_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			mexp_pkg::ST_IDLE: begin
				if (start) begin
					exp_q <= exponent;
					bit_q <= CW'(OPERAND_BITS - 1);
					z_q   <= '0;
				end
			end
			mexp_pkg::ST_RED: begin
				if (mm_done) begin
					bred_q <= mm_r;
				end
			end
			mexp_pkg::ST_SQR: begin
				if (mm_done) begin
					z_q <= mm_r;
					// hold the bit until its multiply is done
					if (!exp_q[OPERAND_BITS-1]) begin
						exp_q <= {exp_q[OPERAND_BITS-2:0], 1'b0};
						bit_q <= bit_q - 1'b1;
					end
				end
			end
			mexp_pkg::ST_MUL: begin
				if (mm_done) begin
					z_q   <= mm_r;
					exp_q <= {exp_q[OPERAND_BITS-2:0], 1'b0};
					bit_q <= bit_q - 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign busy         = (state_q != mexp_pkg::ST_IDLE);
	assign done         = (state_q == mexp_pkg::ST_FIN);
	assign power_result = z_q;

endmodule

`default_nettype wire

### rtl/core/modular_exponentiation_top.sv
// An item takes n = W + 1 + popcount(exponent) modular products, W = OPERAND_BITS,
// on the single bit-serial multiplier, which sets the throughput; none when the
// modulus is zero. A new start is taken only when idle, after the previous done.
// The done strobe lasts one cycle and cannot be stalled.
// Reset (arst_n low) returns to idle and sets the modulus to 1.
// ---------------------------------------------------------------------------
// modular_exponentiation_top
// Computes base^exponent mod modulus by square-and-multiply over a shared
// bit-serial modular multiplier; holds the modulus register.
// ---------------------------------------------------------------------------
`default_nettype none

module modular_exponentiation_top #(
	parameter int OPERAND_BITS = mexp_pkg::OPERAND_BITS_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	output logic                         busy,
	input  wire logic [OPERAND_BITS-1:0] base,
	input  wire logic [OPERAND_BITS-1:0] exponent,
	output logic                         done,
	output logic      [OPERAND_BITS-1:0] power_result,
	input  wire logic                    cfg_valid,
	output logic                         cfg_ready,
	input  wire logic [OPERAND_BITS-1:0] cfg_data
);

	logic [OPERAND_BITS-1:0] modulus_q;
	logic                    mm_go;
	logic [OPERAND_BITS-1:0] mm_a;
	logic [OPERAND_BITS-1:0] mm_b;
	logic [OPERAND_BITS-1:0] mm_r;
	mexp_pkg::mm_stat_t      mm_stat;

	assign cfg_ready = !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= OPERAND_BITS'(1);
		end else if (cfg_valid && cfg_ready) begin
			modulus_q <= cfg_data;
		end
	end

	mexp_ctrl #(
		.OPERAND_BITS(OPERAND_BITS)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.base         (base),
		.exponent     (exponent),
		.modulus      (modulus_q),
		.mm_stat      (mm_stat),
		.mm_r         (mm_r),
		.mm_go        (mm_go),
		.mm_a         (mm_a),
		.mm_b         (mm_b),
		.busy         (busy),
		.done         (done),
		.power_result (power_result)
	);

	mexp_modmul #(
		.OPERAND_BITS(OPERAND_BITS)
	) u_modmul (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (mm_go),
		.a       (mm_a),
		.b       (mm_b),
		.modulus (modulus_q),
		.stat    (mm_stat),
		.r       (mm_r)
	);

endmodule

`default_nettype wire

### rtl/core/mexp_checker.sv
// ---------------------------------------------------------------------------
// mexp_checker
// Port-level checks on the command handshake and the result strobe.
// ---------------------------------------------------------------------------
`default_nettype none

module mexp_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic done,
	input wire logic cfg_ready
);

	// a taken command makes the block busy on the next cycle
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy did not rise after an accepted command");

	// the strobe comes only while busy, and the block is free right after it
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("done strobe while idle");

	a_done_release: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> (!busy && !done))
		else $error("block not released after done strobe");

	// the register port is closed while an item is in flight
	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready == !busy)
		else $error("cfg_ready open while busy");

endmodule

bind modular_exponentiation_top mexp_checker u_mexp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.done      (done),
	.cfg_ready (cfg_ready)
);

`default_nettype wire
